/* rtl/core/spcc_pkg.sv */
// ----------------------------------------------------------------------------
// spcc_pkg
// Shared widths, reset values and byte codes for the servo PWM command
// controller and its channel interfaces.
// ----------------------------------------------------------------------------
package spcc_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned WIDTH_W  = 14;
  localparam int unsigned LEVEL_W  = 4;
  localparam int unsigned UPD_CH_W = 2;

  // Defaults for the top-level parameters
  localparam int unsigned NUM_CHANNELS_DEF = 4;
  localparam int unsigned NUM_DIGITS_DEF   = 4;

  // Reset values
  localparam logic [WIDTH_W-1:0] RESET_WIDTH = WIDTH_W'(1500);
  localparam logic [COUNT_W-1:0] RESET_TOP   = COUNT_W'(20000);

  // Command byte codes
  localparam logic [BYTE_W-1:0] CMD_START  = 8'h73;  // 's'
  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;  // '9'

  // Item kinds
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_BYTE = 1'b1;

endpackage

/* rtl/core/spcc_in_if.sv */
// ----------------------------------------------------------------------------
// spcc_in_if
// Input channel: one timer tick or one received serial byte per word.
// ----------------------------------------------------------------------------
interface spcc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [spcc_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, func, rx_byte, input ready);
  modport sink   (input valid, func, rx_byte, output ready);
endinterface

/* rtl/core/spcc_out_if.sv */
// ----------------------------------------------------------------------------
// spcc_out_if
// Result channel: servo levels and command-update report, one word per item.
// ----------------------------------------------------------------------------
interface spcc_out_if;
  logic                            valid;
  logic                            ready;
  logic [spcc_pkg::LEVEL_W-1:0]    pwm_levels;
  logic                            update_valid;
  logic [spcc_pkg::UPD_CH_W-1:0]   update_channel;
  logic [spcc_pkg::WIDTH_W-1:0]    update_value;

  modport source (output valid, pwm_levels, update_valid, update_channel, update_value,
                  input ready);
  modport sink   (input valid, pwm_levels, update_valid, update_channel, update_value,
                  output ready);
endinterface

/* rtl/core/servo_pwm_command_controller.sv */
// ----------------------------------------------------------------------------
// servo_pwm_command_controller
// Multi-channel RC servo pulse generator driven by a serial command stream.
//
// Each input word is either one timer tick (func = 0) or one received byte
// (func = 1). The command "s", a channel digit and NUM_DIGITS decimal digits
// sets that channel's pending pulse width; any byte that does not fit the
// command is consumed and abandons it. Ticks step a counter from 0 to
// period_top and wrap, loading all pending widths into the active compares
// at the wrap. Every input word yields exactly one result word carrying the
// levels of up to four channels after that word, plus the command update.
// The block takes one word per clock: each word is worked out in a single
// pass of logic into the result register, so a result appears the cycle
// after acceptance, and input stalls only while a held result is not taken.
// The user writes period_top via cfg_wr_en/cfg_wr_data only while idle; unchecked.
// ----------------------------------------------------------------------------
module servo_pwm_command_controller #(
  parameter int unsigned NUM_CHANNELS = spcc_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned NUM_DIGITS   = spcc_pkg::NUM_DIGITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [spcc_pkg::COUNT_W-1:0]   cfg_wr_data,
  spcc_in_if.sink                        in_ch,
  spcc_out_if.source                     out_ch
);

  localparam int unsigned TGT_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned DCNT_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [spcc_pkg::BYTE_W-1:0] CHAN_LAST =
    spcc_pkg::BYTE_W'(spcc_pkg::ASCII_ZERO + NUM_CHANNELS - 1);
  localparam logic [DCNT_W-1:0] DIGIT_LAST = DCNT_W'(NUM_DIGITS - 1);
  localparam int unsigned NUM_LEVELS = (NUM_CHANNELS < spcc_pkg::LEVEL_W) ?
                                       NUM_CHANNELS : spcc_pkg::LEVEL_W;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_CHAN  = 3'b010,
    PH_DIGIT = 3'b100
  } phase_t;

  typedef logic [spcc_pkg::WIDTH_W-1:0] width_t;

  // State
  logic [spcc_pkg::COUNT_W-1:0] top_r;
  logic [spcc_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  phase_t                       phase_r, phase_nxt;
  logic [TGT_W-1:0]             tgt_r, tgt_nxt;
  logic [DCNT_W-1:0]            dcnt_r, dcnt_nxt;
  width_t                       acc_r, acc_nxt;
  width_t                       pending_r [NUM_CHANNELS];
  width_t                       pending_nxt [NUM_CHANNELS];
  width_t                       active_r [NUM_CHANNELS];
  width_t                       active_nxt [NUM_CHANNELS];

  // Result register
  logic                          out_valid_r;
  logic [spcc_pkg::LEVEL_W-1:0]  levels_r, levels_nxt;
  logic                          upd_valid_r, upd_valid_nxt;
  logic [spcc_pkg::UPD_CH_W-1:0] upd_ch_r, upd_ch_nxt;
  width_t                        upd_val_r;

  logic                          in_acc;
  logic                          is_digit;
  logic [17:0]                   acc_mul;
  logic [3:0]                    tgt_ext;

  // Handshake: result register frees when taken
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign is_digit = in_ch.rx_byte inside {[spcc_pkg::ASCII_ZERO:spcc_pkg::ASCII_NINE]};
  assign acc_mul  = 18'(acc_r) * 18'd10 + 18'(4'(in_ch.rx_byte - spcc_pkg::ASCII_ZERO));
  assign tgt_ext  = 4'(tgt_r);

  // Next state for one word
  always_comb begin
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    tgt_nxt       = tgt_r;
    dcnt_nxt      = dcnt_r;
    acc_nxt       = acc_r;
    upd_valid_nxt = 1'b0;
    upd_ch_nxt    = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      pending_nxt[i] = pending_r[i];
      active_nxt[i]  = active_r[i];
    end

    if (in_ch.func == spcc_pkg::FUNC_TICK) begin
      // counter step, preload at wrap
      if (cnt_r >= top_r) begin
        cnt_nxt = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          active_nxt[i] = pending_r[i];
        end
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end else begin
      // command parser
      phase_nxt = PH_IDLE;
      case (phase_r)
        PH_IDLE: begin
          if (in_ch.rx_byte == spcc_pkg::CMD_START) begin
            phase_nxt = PH_CHAN;
          end
        end
        PH_CHAN: begin
          if (in_ch.rx_byte inside {[spcc_pkg::ASCII_ZERO:CHAN_LAST]}) begin
            tgt_nxt   = TGT_W'(in_ch.rx_byte - spcc_pkg::ASCII_ZERO);
            acc_nxt   = '0;
            dcnt_nxt  = '0;
            phase_nxt = PH_DIGIT;
          end
        end
        PH_DIGIT: begin
          if (is_digit) begin
            acc_nxt = acc_mul[spcc_pkg::WIDTH_W-1:0];
            if (dcnt_r == DIGIT_LAST) begin
              for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (TGT_W'(i) == tgt_r) begin
                  pending_nxt[i] = acc_mul[spcc_pkg::WIDTH_W-1:0];
                end
              end
              upd_valid_nxt = 1'b1;
              upd_ch_nxt    = tgt_ext[1:0];
            end else begin
              dcnt_nxt  = dcnt_r + 1'b1;
              phase_nxt = PH_DIGIT;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Levels after this word
  always_comb begin
    levels_nxt = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      levels_nxt[i] = cnt_nxt < spcc_pkg::COUNT_W'(active_nxt[i]);
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= spcc_pkg::RESET_TOP;
    end else if (cfg_wr_en) begin
      top_r <= cfg_wr_data;
    end
  end

  // Working state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      phase_r <= PH_IDLE;
      tgt_r   <= '0;
      dcnt_r  <= '0;
      acc_r   <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        pending_r[i] <= spcc_pkg::RESET_WIDTH;
        active_r[i]  <= spcc_pkg::RESET_WIDTH;
      end
    end else if (in_acc) begin
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      tgt_r   <= tgt_nxt;
      dcnt_r  <= dcnt_nxt;
      acc_r   <= acc_nxt;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        pending_r[i] <= pending_nxt[i];
        active_r[i]  <= active_nxt[i];
      end
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      levels_r    <= levels_nxt;
      upd_valid_r <= upd_valid_nxt;
      upd_ch_r    <= upd_ch_nxt;
      upd_val_r   <= upd_valid_nxt ? acc_mul[spcc_pkg::WIDTH_W-1:0] : '0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.pwm_levels     = levels_r;
  assign out_ch.update_valid   = upd_valid_r;
  assign out_ch.update_channel = upd_ch_r;
  assign out_ch.update_value   = upd_val_r;

`ifndef SYNTHESIS
  // A word without an update reports channel and value as zero
  a_no_upd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !upd_valid_r) |-> (upd_ch_r == '0 && upd_val_r == '0))
    else $error("result without update carries non-zero fields");

  // A tick at or above top wraps the counter to zero
  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.func == spcc_pkg::FUNC_TICK && cnt_r >= top_r) |=> (cnt_r == '0))
    else $error("counter did not wrap at top");

  // A completed command returns the parser to idle
  a_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && upd_valid_nxt) |=> (phase_r == PH_IDLE))
    else $error("parser not idle after completed command");

  // Bytes never move the counter
  a_byte_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.func == spcc_pkg::FUNC_BYTE) |=> $stable(cnt_r))
    else $error("byte word moved the counter");
`endif

endmodule

/* test/spcc_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spcc_checker
// Watches both channels and the period register port of the servo PWM
// command controller, predicts every result word from the accepted input
// words and compares it field by field with what the block hands out.
// ----------------------------------------------------------------------------
module spcc_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [spcc_pkg::COUNT_W-1:0] cfg_wr_data,
  spcc_in_if                           in_mon,
  spcc_out_if                          out_mon,
  output int                           errors,
  output int                           outstanding,
  output int                           words_checked,
  output int                           updates_seen,
  output int                           wraps_seen
);
  import spcc_pkg::*;

  localparam int NCH  = NUM_CHANNELS_DEF;
  localparam int NDIG = NUM_DIGITS_DEF;

  // Command parser phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_CHANNEL = 3'd1;
  localparam logic [2:0] PH_DIGIT0  = 3'd2;
  localparam logic [2:0] PH_LAST    = 3'(PH_DIGIT0 + NDIG - 1);

  typedef struct packed {
    logic [LEVEL_W-1:0]  levels;
    logic                upd;
    logic [UPD_CH_W-1:0] upd_ch;
    logic [WIDTH_W-1:0]  upd_val;
  } servo_word_t;

  // Predicted block state
  logic [COUNT_W-1:0] top_q;
  logic [COUNT_W-1:0] frame_count;
  logic [2:0]         parse_ph;
  logic [1:0]         cmd_ch;
  logic [WIDTH_W-1:0] digit_acc;
  logic [WIDTH_W-1:0] pending_w [NCH];
  logic [WIDTH_W-1:0] active_w  [NCH];

  servo_word_t due_words[$];

  initial begin
    errors        = 0;
    outstanding   = 0;
    words_checked = 0;
    updates_seen  = 0;
    wraps_seen    = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < 25) begin
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    end
    errors++;
  endtask

  // One input word through the servo state; returns the word it should cause
  task automatic servo_step(input logic f, input logic [BYTE_W-1:0] b,
                            output servo_word_t r);
    int unsigned acc_next;
    int          i;
    r = '0;
    if (f == FUNC_TICK) begin
      // counter test is >=, so a lowered top wraps on the next tick
      if (frame_count >= top_q) begin
        frame_count = '0;
        for (i = 0; i < NCH; i++) active_w[i] = pending_w[i];
        wraps_seen++;
      end else begin
        frame_count = frame_count + 1'b1;
      end
    end else if (parse_ph == PH_IDLE) begin
      if (b == CMD_START) parse_ph = PH_CHANNEL;
    end else if (parse_ph == PH_CHANNEL) begin
      if (b >= ASCII_ZERO && b < ASCII_ZERO + NCH) begin
        cmd_ch    = 2'(b - ASCII_ZERO);
        digit_acc = '0;
        parse_ph  = PH_DIGIT0;
      end else begin
        parse_ph = PH_IDLE;
      end
    end else if (parse_ph >= PH_DIGIT0 && parse_ph <= PH_LAST) begin
      if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
        acc_next  = digit_acc * 10 + (b - ASCII_ZERO);
        digit_acc = WIDTH_W'(acc_next);
        if (parse_ph == PH_LAST) begin
          pending_w[cmd_ch] = digit_acc;
          r.upd     = 1'b1;
          r.upd_ch  = cmd_ch;
          r.upd_val = digit_acc;
          parse_ph  = PH_IDLE;
          updates_seen++;
        end else begin
          parse_ph = parse_ph + 1'b1;
        end
      end else begin
        // unexpected byte is swallowed, even an 's'
        parse_ph = PH_IDLE;
      end
    end else begin
      parse_ph = PH_IDLE;
    end

    for (i = 0; i < NCH; i++) r.levels[i] = (frame_count < active_w[i]);
  endtask

  // Compare accepted results first, then predict the accepted input word
  always @(posedge clk) begin
    servo_word_t got;
    servo_word_t want;
    servo_word_t pred;
    int          i;
    if (!rst_n) begin
      top_q       = RESET_TOP;
      frame_count = '0;
      parse_ph    = PH_IDLE;
      cmd_ch      = '0;
      digit_acc   = '0;
      for (i = 0; i < NCH; i++) begin
        pending_w[i] = RESET_WIDTH;
        active_w[i]  = RESET_WIDTH;
      end
      due_words.delete();
    end else begin
      if (cfg_wr_en) top_q = cfg_wr_data;

      if (out_mon.valid && out_mon.ready) begin
        got.levels  = out_mon.pwm_levels;
        got.upd     = out_mon.update_valid;
        got.upd_ch  = out_mon.update_channel;
        got.upd_val = out_mon.update_value;
        if (due_words.size() == 0) begin
          report_mismatch("result word with nothing due, levels", got.levels, 0);
        end else begin
          want = due_words.pop_front();
          if (got.levels !== want.levels)
            report_mismatch("pwm_levels", got.levels, want.levels);
          if (got.upd !== want.upd)
            report_mismatch("update_valid", got.upd, want.upd);
          if (got.upd_ch !== want.upd_ch)
            report_mismatch("update_channel", got.upd_ch, want.upd_ch);
          if (got.upd_val !== want.upd_val)
            report_mismatch("update_value", got.upd_val, want.upd_val);
          words_checked++;
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        servo_step(in_mon.func, in_mon.rx_byte, pred);
        due_words.push_back(pred);
      end
    end
    outstanding = due_words.size();
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives ticks and serial command bytes into the servo PWM command
// controller over a run of period settings, with random gaps on both
// channels, and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench;
  import spcc_pkg::*;

  localparam int N_PHASE_WORDS = 185;
  localparam int N_PHASES      = 9;
  localparam int LONG_HOLD     = 300;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [COUNT_W-1:0]  cfg_wr_data;

  spcc_in_if  in_ch ();
  spcc_out_if out_ch ();

  int errors;
  int outstanding;
  int words_checked;
  int updates_seen;
  int wraps_seen;

  int words_sent = 0;
  bit src_gaps   = 1'b0;
  bit sink_gaps  = 1'b0;
  bit hold_req   = 1'b0;

  // Mostly small tops so that frames wrap often; counter above top follows the
  // largest setting
  logic [COUNT_W-1:0] phase_tops [N_PHASES] =
    '{16'd7, 16'd0, 16'd40, 16'd1, 16'd15, 16'd65535, 16'd60, 16'd3, 16'd150};

  always #4 clk = ~clk;

  servo_pwm_command_controller dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  spcc_checker servo_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .errors        (errors),
    .outstanding   (outstanding),
    .words_checked (words_checked),
    .updates_seen  (updates_seen),
    .wraps_seen    (wraps_seen)
  );

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [BYTE_W-1:0] digit_byte(input int d);
    return BYTE_W'(ASCII_ZERO + d);
  endfunction

  // One word on the input channel; returns at the falling edge after acceptance
  task automatic put_word(input logic f, input logic [BYTE_W-1:0] b);
    int gap;
    gap = src_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= f;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // rx_byte is don't-care on ticks, so let it wander
  task automatic put_tick();
    put_word(FUNC_TICK, BYTE_W'($urandom_range(0, 255)));
  endtask

  // Full command, optionally with ticks slipped in between bytes
  task automatic put_command(input int ch, input int value, input bit mix);
    int div;
    put_word(FUNC_BYTE, CMD_START);
    if (mix && $urandom_range(0, 4) == 0) put_tick();
    put_word(FUNC_BYTE, digit_byte(ch));
    div = 1000;
    while (div > 0) begin
      if (mix && $urandom_range(0, 4) == 0) put_tick();
      put_word(FUNC_BYTE, digit_byte((value / div) % 10));
      div = div / 10;
    end
  endtask

  // Stray bytes and commands broken off at various points
  task automatic put_noise();
    logic [BYTE_W-1:0] b;
    int                n;
    case ($urandom_range(0, 3))
      0: put_word(FUNC_BYTE, BYTE_W'($urandom_range(0, 255)));
      1: begin
        do b = BYTE_W'($urandom_range(0, 255));
        while (b >= ASCII_ZERO && b < ASCII_ZERO + NUM_CHANNELS_DEF);
        put_word(FUNC_BYTE, CMD_START);
        put_word(FUNC_BYTE, b);
      end
      2: begin
        put_word(FUNC_BYTE, CMD_START);
        put_word(FUNC_BYTE, digit_byte($urandom_range(0, NUM_CHANNELS_DEF - 1)));
        n = $urandom_range(0, NUM_DIGITS_DEF - 1);
        repeat (n) put_word(FUNC_BYTE, digit_byte($urandom_range(0, 9)));
        if ($urandom_range(0, 3) == 0) begin
          b = CMD_START;
        end else begin
          do b = BYTE_W'($urandom_range(0, 255));
          while (b >= ASCII_ZERO && b <= ASCII_NINE);
        end
        put_word(FUNC_BYTE, b);
      end
      default: begin
        put_word(FUNC_BYTE, CMD_START);
        put_word(FUNC_BYTE, CMD_START);
      end
    endcase
  endtask

  // Widths mostly around the frame length, sometimes anywhere
  function automatic int pick_width(input int top);
    int hi;
    hi = top + top / 8 + 2;
    if (hi > 9999) hi = 9999;
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, hi);
    return $urandom_range(0, 9999);
  endfunction

  // Stop offering and wait until every result has been taken
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_top(input logic [COUNT_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [COUNT_W-1:0] top, input bit src_idle,
                           input bit sink_idle, input bit hold);
    int target;
    int r;
    drain();
    write_top(top);
    src_gaps  = src_idle;
    sink_gaps = sink_idle;
    if (hold) hold_req = 1'b1;
    target = words_sent + N_PHASE_WORDS;
    while (words_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 85) put_tick();
      else if (r < 96) put_command($urandom_range(0, NUM_CHANNELS_DEF - 1),
                                   pick_width(top), 1'b1);
      else put_noise();
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin : sink_side
    int stall;
    int hold_left;
    stall        = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (sink_gaps && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int i;
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_ch.valid   = 1'b0;
    in_ch.func    = FUNC_TICK;
    in_ch.rx_byte = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset widths, both width extremes, broken commands
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    put_tick();
    put_tick();
    put_command(0, 0, 1'b0);
    put_command(3, 9999, 1'b0);
    // an 's' where the channel digit belongs is swallowed
    put_word(FUNC_BYTE, CMD_START);
    put_word(FUNC_BYTE, CMD_START);
    put_word(FUNC_BYTE, digit_byte(2));
    // bad digit, then a channel out of range
    put_word(FUNC_BYTE, CMD_START);
    put_word(FUNC_BYTE, digit_byte(1));
    put_word(FUNC_BYTE, digit_byte(5));
    put_word(FUNC_BYTE, ASCII_NINE + 8'd1);
    put_word(FUNC_BYTE, CMD_START);
    put_word(FUNC_BYTE, digit_byte(NUM_CHANNELS_DEF));
    put_word(FUNC_BYTE, 8'h00);
    put_word(FUNC_BYTE, 8'hFF);

    // Random phases, each under its own period setting
    for (i = 0; i < N_PHASES; i++) begin
      run_phase(phase_tops[i], (i % 3) != 0, (i % 4) != 1, i == 3);
    end
    drain();
    repeat (10) @(negedge clk);

    $display("Run covered %0d result words, %0d width commands and %0d frame wraps",
             words_checked, updates_seen, wraps_seen);
    $display("across %0d period settings with stalls on both channels", N_PHASES + 1);
    if (errors == 0) begin
      $display("servo_pwm_command_controller test passed");
    end else begin
      $display("servo_pwm_command_controller test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5000000;
    $display("servo_pwm_command_controller test failed");
    $finish;
  end

endmodule
